// ===== hdl/caf_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN acceptance filter bank package
// Shared types, constants and identifier packing for the filter bank.
// ----------------------------------------------------------------------------
`default_nettype none

package caf_pkg;

  localparam int unsigned FilterSlotsDefault = 32;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned IdW     = 29;
  localparam int unsigned FifoW   = 5;
  localparam int unsigned StdW    = 11;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 16;

  localparam logic [IdW-1:0] Id29Bits = 29'h1FFF_FFFF;
  localparam logic [IdW-1:0] StdBits  = 29'h0000_07FF;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_MATCH = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic [IdW:0]     ident;   // bit 29 is the extended flag
    logic [IdW-1:0]   mask;
    logic [FifoW-1:0] target;
  } entry_t;

  typedef struct packed {
    logic             matched;
    logic [SlotW-1:0] slot;
    logic [FifoW-1:0] fifo;
  } result_t;

  // base part low, extension part above
  function automatic logic [IdW-1:0] pack_id(input logic [IdW-1:0] id, input logic ext);
    logic [IdW-1:0] r;
    if (ext) begin
      r = {id[17:0], id[28:18]};
    end else begin
      r = {18'd0, id[StdW-1:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/can_acceptance_filter_bank_core.sv =====
// ----------------------------------------------------------------------------
// CAN acceptance filter bank core
// Stores filter slots and matches received identifiers, lowest slot first.
// ----------------------------------------------------------------------------
// Write transaction: the result passes through ST_DONE into the output register.
// Match transaction: one slot read per cycle from the slot memory; the scan
//   stops at the first hit or after the last slot.
// One item in work at a time; the output register lets the next item enter
//   while a result still waits.
// Reset clears every slot enable and the control state; slot contents stay.
`default_nettype none

module can_acceptance_filter_bank_core #(
  parameter int unsigned FILTER_SLOTS = caf_pkg::FilterSlotsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // slot[4:0], id_value[33:5], mask_value[62:34], enable[63],
  // dest_fifo[68:64], is_extended[69], zero[71:70]
  input  wire logic [caf_pkg::InDataW-1:0]  s_axis_tdata,
  // opcode[0]
  input  wire logic                         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // matched[0], match_slot[5:1], match_fifo[10:6], zero[15:11]
  output logic [caf_pkg::OutDataW-1:0]      m_axis_tdata
);
  import caf_pkg::*;

  localparam int unsigned AddrW = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(FILTER_SLOTS + 1);

  logic [SlotW-1:0] in_slot;
  logic [IdW-1:0]   in_id;
  logic [IdW-1:0]   in_mask;
  logic             in_enable;
  logic [FifoW-1:0] in_fifo;
  logic             in_ext;

  assign in_slot   = s_axis_tdata[4:0];
  assign in_id     = s_axis_tdata[33:5];
  assign in_mask   = s_axis_tdata[62:34];
  assign in_enable = s_axis_tdata[63];
  assign in_fifo   = s_axis_tdata[68:64];
  assign in_ext    = s_axis_tdata[69];

  state_e state_q, state_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [SlotW-1:0] cmp_idx_q, cmp_idx_d;
  logic [IdW-1:0]   rx_q, rx_d;
  logic             rx_ext_q, rx_ext_d;
  result_t          res_q, res_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;

  logic             in_fire;
  logic             wr_ext;
  logic             slot_ok;
  entry_t           wr_entry;
  logic             we;
  logic             re;
  entry_t           rd_entry;
  logic             rd_on;
  logic             hit;
  logic             out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign wr_ext  = (in_id > StdBits);
  assign slot_ok = ({1'b0, in_slot} < (SlotW + 1)'(FILTER_SLOTS));

  always_comb begin
    wr_entry.ident  = {wr_ext, pack_id(in_id, wr_ext)};
    wr_entry.mask   = (in_mask != '0) ? pack_id(in_mask, wr_ext)
                                      : pack_id(wr_ext ? Id29Bits : StdBits, wr_ext);
    wr_entry.target = in_fifo;
  end

  assign we = in_fire && (opcode_e'(s_axis_tuser) == OP_WRITE) && slot_ok;
  assign re = (state_q == ST_SCAN) && !hit && (idx_q != CntW'(FILTER_SLOTS));

  caf_slot_ram #(
    .FILTER_SLOTS (FILTER_SLOTS),
    .AddrW        (AddrW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (in_slot[AddrW-1:0]),
    .wdata_i (wr_entry),
    .wen_i   (in_enable),
    .re_i    (re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rd_entry),
    .ron_o   (rd_on)
  );

  logic cmp_valid_q, cmp_valid_d;

  assign hit = cmp_valid_q && rd_on && (rd_entry.ident[IdW] == rx_ext_q) &&
               (((rx_q ^ rd_entry.ident[IdW-1:0]) & rd_entry.mask) == '0);

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_valid_d = 1'b0;
    rx_d        = rx_q;
    rx_ext_d    = rx_ext_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (opcode_e'(s_axis_tuser) == OP_MATCH) begin
            rx_d     = pack_id(in_id, in_ext);
            rx_ext_d = in_ext;
            idx_d    = '0;
            state_d  = ST_SCAN;
          end else begin
            res_d   = '0;
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_d.matched = 1'b1;
          res_d.slot    = cmp_idx_q;
          res_d.fifo    = rd_entry.target;
          state_d       = ST_DONE;
        end else if (idx_q == CntW'(FILTER_SLOTS)) begin
          res_d   = '0;
          state_d = ST_DONE;
        end else begin
          cmp_valid_d = 1'b1;
          cmp_idx_d   = SlotW'(idx_q);
          idx_d       = idx_q + CntW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    rx_q      <= rx_d;
    rx_ext_q  <= rx_ext_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - $bits(result_t))'(0),
                          out_q.fifo, out_q.slot, out_q.matched};

  property p_write_done;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_fire && opcode_e'(s_axis_tuser) == OP_WRITE) |=> (state_q == ST_DONE);
  endproperty
  a_write_done: assert property (p_write_done)
    else $error("write transaction did not complete in one cycle");

  property p_hit_in_range;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && out_q.matched) |-> ({1'b0, out_q.slot} < (SlotW + 1)'(FILTER_SLOTS));
  endproperty
  a_hit_in_range: assert property (p_hit_in_range)
    else $error("reported slot beyond the filter bank");

  property p_miss_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && !out_q.matched) |-> (out_q.slot == '0 && out_q.fifo == '0);
  endproperty
  a_miss_zero: assert property (p_miss_zero)
    else $error("non-matching result carries slot or fifo");

  property p_scan_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_SCAN) |-> (idx_q <= CntW'(FILTER_SLOTS));
  endproperty
  a_scan_bound: assert property (p_scan_bound)
    else $error("scan index past the last slot");

endmodule

`default_nettype wire

// ===== hdl/caf_slot_ram.sv =====
// ----------------------------------------------------------------------------
// Filter slot store
// Synchronous slot memory with one write and one registered read port,
// plus per-slot enable flops cleared at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module caf_slot_ram #(
  parameter int unsigned FILTER_SLOTS = caf_pkg::FilterSlotsDefault,
  parameter int unsigned AddrW = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire caf_pkg::entry_t wdata_i,
  input  wire logic            wen_i,
  input  wire logic            re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output caf_pkg::entry_t      rdata_o,
  output logic                 ron_o
);
  import caf_pkg::*;

  entry_t mem [FILTER_SLOTS];
  logic   on_q [FILTER_SLOTS];
  entry_t rdata_q;
  logic   ron_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FILTER_SLOTS; i++) begin
        on_q[i] <= 1'b0;
      end
      ron_q <= 1'b0;
    end else begin
      if (we_i) begin
        on_q[waddr_i] <= wen_i;
      end
      if (re_i) begin
        ron_q <= on_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;
  assign ron_o   = ron_q;

  property p_no_rw_overlap;
    @(posedge clk_i) disable iff (!rst_ni) !(we_i && re_i);
  endproperty
  a_no_rw_overlap: assert property (p_no_rw_overlap)
    else $error("slot store written and scanned in the same cycle");

  property p_read_reg;
    @(posedge clk_i) disable iff (!rst_ni) !re_i |=> $stable(ron_o);
  endproperty
  a_read_reg: assert property (p_read_reg)
    else $error("enable read changed without a read");

  property p_write_enable;
    @(posedge clk_i) disable iff (!rst_ni)
      (we_i && re_i == 1'b0) |=> on_q[$past(waddr_i)] == $past(wen_i);
  endproperty
  a_write_enable: assert property (p_write_enable)
    else $error("slot enable not stored");

endmodule

`default_nettype wire
